[rtl/core/nnda_pkg.sv]
package nnda_pkg;

   localparam int CHAN_W     = 8;
   localparam int FUNC_W     = 2;
   localparam int CFG_W      = 9;
   localparam int CSR_IDX_W  = 4;

   localparam int DEF_MAX_SRC_SIDE = 256;
   localparam int DEF_MAX_OUT_SIDE = 256;

   localparam logic [FUNC_W-1:0] FUNC_STORE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_EMIT  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_NEW   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_WIDTH  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_HEIGHT = 4'd3;

   localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 9'd1;
   localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 9'd1;
   localparam logic [CFG_W-1:0] RST_OUT_WIDTH  = 9'd40;
   localparam logic [CFG_W-1:0] RST_OUT_HEIGHT = 9'd20;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

endpackage

[rtl/core/nnda_ifs.sv]
interface nnda_req_if;
   logic                          valid;
   logic                          ready;
   logic [nnda_pkg::FUNC_W-1:0]   func;
   logic [nnda_pkg::CHAN_W-1:0]   in_red;
   logic [nnda_pkg::CHAN_W-1:0]   in_green;
   logic [nnda_pkg::CHAN_W-1:0]   in_blue;

   modport source (output valid, func, in_red, in_green, in_blue, input ready);
   modport sink   (input valid, func, in_red, in_green, in_blue, output ready);
endinterface

interface nnda_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [nnda_pkg::CHAN_W-1:0]   out_red;
   logic [nnda_pkg::CHAN_W-1:0]   out_green;
   logic [nnda_pkg::CHAN_W-1:0]   out_blue;
   logic                          grid_done;
   logic [nnda_pkg::CHAN_W-1:0]   avg_red;
   logic [nnda_pkg::CHAN_W-1:0]   avg_green;
   logic [nnda_pkg::CHAN_W-1:0]   avg_blue;

   modport source (output valid, out_red, out_green, out_blue, grid_done,
                   avg_red, avg_green, avg_blue, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, grid_done,
                   avg_red, avg_green, avg_blue, output ready);
endinterface

interface nnda_csr_if;
   logic                             valid;
   logic                             ready;
   logic [nnda_pkg::CSR_IDX_W-1:0]   index;
   logic [nnda_pkg::CFG_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/nnda_div.sv]
// Restoring divider, one quotient bit per cycle.
module nnda_div #(
   parameter int DW = 26,
   parameter int VW = 18
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CNTW = $clog2(DW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [VW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   quo_ff, quo_in;
   logic [VW-1:0]   dsr_ff, dsr_in;
   logic [VW:0]     trial;
   logic [VW:0]     diff;
   logic            fits;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[VW-1:0] : trial[VW-1:0];
         quo_in = {quo_ff[DW-2:0], fits};
         cnt_in = cnt_ff + CNTW'(1);
         if (cnt_ff == CNTW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/core/nearest_neighbor_downsample_average.sv]
// Store and new-picture transactions: one per cycle while idle, no result.
// Emit transaction: the bit-serial dividers (DW quotient bits) map the grid position to
// a source pixel, which is read and summed; on the last grid pixel they form the means.
// One emit at a time; the next transaction is taken when the result is in the output register.
// Synchronous reset clears control state, sums and grid position and restores register
// defaults; the frame store is not cleared and needs no clearing pass.
module nearest_neighbor_downsample_average #(
   parameter int MAX_SRC_SIDE = nnda_pkg::DEF_MAX_SRC_SIDE,
   parameter int MAX_OUT_SIDE = nnda_pkg::DEF_MAX_OUT_SIDE
) (
   input  logic        clock,
   input  logic        reset,
   nnda_req_if.sink    req_chan,
   nnda_rsp_if.source  rsp_chan,
   nnda_csr_if.sink    csr_chan
);

   localparam int SSW   = $clog2(MAX_SRC_SIDE + 1);
   localparam int OSW   = $clog2(MAX_OUT_SIDE + 1);
   localparam int SXW   = $clog2(MAX_SRC_SIDE);
   localparam int DEPTH = MAX_SRC_SIDE * MAX_SRC_SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int LPW   = $clog2(DEPTH + 1);
   localparam int TW    = 2 * SSW;
   localparam int PW    = OSW + SSW;
   localparam int CW    = 2 * OSW;
   localparam int SUMW  = CW + nnda_pkg::CHAN_W;
   localparam int DW    = (PW > SUMW) ? PW : SUMW;
   localparam int VW    = CW;
   localparam int MW    = SXW + SSW + 1;
   localparam int CFW   = nnda_pkg::CFG_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL  = 4'd1;
   localparam logic [3:0] S_DIVS = 4'd2;
   localparam logic [3:0] S_DIVW = 4'd3;
   localparam logic [3:0] S_ADDR = 4'd4;
   localparam logic [3:0] S_READ = 4'd5;
   localparam logic [3:0] S_ACC  = 4'd6;
   localparam logic [3:0] S_AVGS = 4'd7;
   localparam logic [3:0] S_AVGW = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   logic [3:0]      state_ff, state_in;
   logic [CFW-1:0]  src_w_ff, src_w_in, src_h_ff, src_h_in;
   logic [CFW-1:0]  out_w_ff, out_w_in, out_h_ff, out_h_in;
   logic [LPW-1:0]  load_pos_ff, load_pos_in;
   logic [OSW-1:0]  col_ff, col_in, row_ff, row_in;
   logic [SUMW-1:0] sum_r_ff, sum_r_in, sum_g_ff, sum_g_in, sum_b_ff, sum_b_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [PW-1:0]   prod_x_ff, prod_y_ff;
   logic [SXW-1:0]  sx_ff, sy_ff;
   logic [AW-1:0]   addr_ff;
   nnda_pkg::pixel_type rd_ff;
   logic [CW-1:0]   count_ff;
   logic            last_ff;
   logic [nnda_pkg::CHAN_W-1:0] avg_r_ff, avg_g_ff, avg_b_ff;
   nnda_pkg::pixel_type rsp_pix_ff;
   logic            rsp_done_ff;
   logic [nnda_pkg::CHAN_W-1:0] rsp_avg_r_ff, rsp_avg_g_ff, rsp_avg_b_ff;

   nnda_pkg::pixel_type frame_mem [0:DEPTH-1];

   logic [SSW-1:0]  sw, sh;
   logic [OSW-1:0]  ow, oh;
   logic [TW-1:0]   total;
   logic            req_acc;
   logic            store_we;
   logic            is_last;
   logic [OSW-1:0]  col_next;
   logic [MW-1:0]   addr_full;
   logic            out_load;

   logic            div_start;
   logic            avg_phase;
   logic [DW-1:0]   dvd0, dvd1, dvd2;
   logic [VW-1:0]   dsr0, dsr1, dsr2;
   logic            div_done0, div_done1, div_done2;
   logic [DW-1:0]   quo0, quo1, quo2;

   assign sw = (src_w_ff == '0) ? SSW'(1) :
               (32'(src_w_ff) > 32'(MAX_SRC_SIDE)) ? SSW'(MAX_SRC_SIDE) : SSW'(src_w_ff);
   assign sh = (src_h_ff == '0) ? SSW'(1) :
               (32'(src_h_ff) > 32'(MAX_SRC_SIDE)) ? SSW'(MAX_SRC_SIDE) : SSW'(src_h_ff);
   assign ow = (out_w_ff == '0) ? OSW'(1) :
               (32'(out_w_ff) > 32'(MAX_OUT_SIDE)) ? OSW'(MAX_OUT_SIDE) : OSW'(out_w_ff);
   assign oh = (out_h_ff == '0) ? OSW'(1) :
               (32'(out_h_ff) > 32'(MAX_OUT_SIDE)) ? OSW'(MAX_OUT_SIDE) : OSW'(out_h_ff);

   assign total     = TW'(sw) * TW'(sh);
   assign req_acc   = req_chan.valid && req_chan.ready;
   assign store_we  = req_acc && (req_chan.func == nnda_pkg::FUNC_STORE) &&
                      (TW'(load_pos_ff) < total);
   assign is_last   = (col_ff == ow - OSW'(1)) && (row_ff == oh - OSW'(1));
   assign col_next  = col_ff + OSW'(1);
   assign addr_full = MW'(sy_ff) * MW'(sw) + MW'(sx_ff);
   assign out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;

   // dividers: source coordinates first, channel means on the last grid pixel
   assign div_start = (state_ff == S_DIVS) || (state_ff == S_AVGS);
   assign avg_phase = (state_ff == S_AVGS);
   assign dvd0 = avg_phase ? DW'(sum_r_ff) : DW'(prod_x_ff);
   assign dvd1 = avg_phase ? DW'(sum_g_ff) : DW'(prod_y_ff);
   assign dvd2 = avg_phase ? DW'(sum_b_ff) : '0;
   assign dsr0 = avg_phase ? count_ff : VW'(ow);
   assign dsr1 = avg_phase ? count_ff : VW'(oh);
   assign dsr2 = avg_phase ? count_ff : VW'(1);

   nnda_div #(.DW(DW), .VW(VW)) u_div0 (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dvd0), .divisor(dsr0),
      .done(div_done0), .quotient(quo0)
   );
   nnda_div #(.DW(DW), .VW(VW)) u_div1 (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dvd1), .divisor(dsr1),
      .done(div_done1), .quotient(quo1)
   );
   nnda_div #(.DW(DW), .VW(VW)) u_div2 (
      .clock(clock), .reset(reset), .start(div_start), .dividend(dvd2), .divisor(dsr2),
      .done(div_done2), .quotient(quo2)
   );

   always_comb begin
      state_in     = state_ff;
      src_w_in     = src_w_ff;
      src_h_in     = src_h_ff;
      out_w_in     = out_w_ff;
      out_h_in     = out_h_ff;
      load_pos_in  = load_pos_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      sum_r_in     = sum_r_ff;
      sum_g_in     = sum_g_ff;
      sum_b_in     = sum_b_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            nnda_pkg::REG_SRC_WIDTH:  src_w_in = csr_chan.data;
            nnda_pkg::REG_SRC_HEIGHT: src_h_in = csr_chan.data;
            nnda_pkg::REG_OUT_WIDTH:  out_w_in = csr_chan.data;
            nnda_pkg::REG_OUT_HEIGHT: out_h_in = csr_chan.data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_chan.func)
                  nnda_pkg::FUNC_STORE: begin
                     if (TW'(load_pos_ff) < total) begin
                        load_pos_in = load_pos_ff + LPW'(1);
                     end else begin
                        load_pos_in = LPW'(total);
                     end
                  end
                  nnda_pkg::FUNC_EMIT: begin
                     // grid shrank under the current position: restart it
                     if (col_ff >= ow || row_ff >= oh) begin
                        col_in   = '0;
                        row_in   = '0;
                        sum_r_in = '0;
                        sum_g_in = '0;
                        sum_b_in = '0;
                     end
                     state_in = S_MUL;
                  end
                  nnda_pkg::FUNC_NEW: begin
                     load_pos_in = '0;
                     col_in      = '0;
                     row_in      = '0;
                     sum_r_in    = '0;
                     sum_g_in    = '0;
                     sum_b_in    = '0;
                  end
                  default: ;
               endcase
            end
         end
         S_MUL:  state_in = S_DIVS;
         S_DIVS: state_in = S_DIVW;
         S_DIVW: begin
            if (div_done0) begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: state_in = S_READ;
         S_READ: state_in = S_ACC;
         S_ACC: begin
            sum_r_in = sum_r_ff + SUMW'(rd_ff.red);
            sum_g_in = sum_g_ff + SUMW'(rd_ff.green);
            sum_b_in = sum_b_ff + SUMW'(rd_ff.blue);
            if (is_last) begin
               col_in   = '0;
               row_in   = '0;
               state_in = S_AVGS;
            end else begin
               if (col_next >= ow) begin
                  col_in = '0;
                  row_in = row_ff + OSW'(1);
               end else begin
                  col_in = col_next;
               end
               state_in = S_OUT;
            end
         end
         S_AVGS: state_in = S_AVGW;
         S_AVGW: begin
            if (div_done0) begin
               sum_r_in = '0;
               sum_g_in = '0;
               sum_b_in = '0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         src_w_ff     <= nnda_pkg::RST_SRC_WIDTH;
         src_h_ff     <= nnda_pkg::RST_SRC_HEIGHT;
         out_w_ff     <= nnda_pkg::RST_OUT_WIDTH;
         out_h_ff     <= nnda_pkg::RST_OUT_HEIGHT;
         load_pos_ff  <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         sum_r_ff     <= '0;
         sum_g_ff     <= '0;
         sum_b_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_w_ff     <= src_w_in;
         src_h_ff     <= src_h_in;
         out_w_ff     <= out_w_in;
         out_h_ff     <= out_h_in;
         load_pos_ff  <= load_pos_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         sum_r_ff     <= sum_r_in;
         sum_g_ff     <= sum_g_in;
         sum_b_ff     <= sum_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         prod_x_ff <= PW'(col_ff) * PW'(sw);
         prod_y_ff <= PW'(row_ff) * PW'(sh);
      end
      if (state_ff == S_DIVW && div_done0) begin
         sx_ff <= (quo0 >= DW'(sw)) ? SXW'(sw - SSW'(1)) : SXW'(quo0);
         sy_ff <= (quo1 >= DW'(sh)) ? SXW'(sh - SSW'(1)) : SXW'(quo1);
      end
      if (state_ff == S_ADDR) begin
         addr_ff <= addr_full[AW-1:0];
      end
      if (state_ff == S_ACC) begin
         count_ff <= CW'(ow) * CW'(oh);
         last_ff  <= is_last;
         avg_r_ff <= '0;
         avg_g_ff <= '0;
         avg_b_ff <= '0;
      end
      if (state_ff == S_AVGW && div_done0) begin
         avg_r_ff <= quo0[nnda_pkg::CHAN_W-1:0];
         avg_g_ff <= quo1[nnda_pkg::CHAN_W-1:0];
         avg_b_ff <= quo2[nnda_pkg::CHAN_W-1:0];
      end
      if (out_load) begin
         rsp_pix_ff   <= rd_ff;
         rsp_done_ff  <= last_ff;
         rsp_avg_r_ff <= avg_r_ff;
         rsp_avg_g_ff <= avg_g_ff;
         rsp_avg_b_ff <= avg_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         frame_mem[load_pos_ff[AW-1:0]] <= {req_chan.in_red, req_chan.in_green,
                                            req_chan.in_blue};
      end
      if (state_ff == S_READ) begin
         rd_ff <= frame_mem[addr_ff];
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_red   = rsp_pix_ff.red;
   assign rsp_chan.out_green = rsp_pix_ff.green;
   assign rsp_chan.out_blue  = rsp_pix_ff.blue;
   assign rsp_chan.grid_done = rsp_done_ff;
   assign rsp_chan.avg_red   = rsp_avg_r_ff;
   assign rsp_chan.avg_green = rsp_avg_g_ff;
   assign rsp_chan.avg_blue  = rsp_avg_b_ff;

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done0 |-> (state_ff == S_DIVW || state_ff == S_AVGW))
      else $error("divider finished outside a wait state");

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      (div_done1 == div_done0) && (div_done2 == div_done0))
      else $error("dividers out of step");

   a_grid_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && last_ff) |->
         (col_ff == '0 && row_ff == '0 && sum_r_ff == '0 && sum_g_ff == '0 &&
          sum_b_ff == '0))
      else $error("grid not cleared after last pixel");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside output state");

   a_src_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADDR) |-> (SSW'(sx_ff) < sw && SSW'(sy_ff) < sh))
      else $error("source coordinate out of range");

endmodule
